// ===== src/assert_macros.svh =====
// Assertion helpers for shape_overlap_scan. Each macro expects a clock named
// clk and an active-high reset named rst in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/sos_pkg.sv =====
package sos_pkg;

  localparam int DefTableEntries = 64;
  localparam int MaxEntries      = 64;
  localparam int IndexW          = 6;
  // Register stages from table read to the registered hit flag.
  localparam int PipeLat         = 5;
  // Working width for coordinates, box edges and differences.
  localparam int CoordW          = 27;
  localparam int RadW            = 21;

  localparam logic ActWrite = 1'b0;
  localparam logic KindRect = 1'b0;

  typedef struct packed {
    logic               action;
    logic [5:0]         entry_index;
    logic               skip_own;
    logic               entry_live;
    logic               shape_kind;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic [19:0]        extent_a;
    logic [19:0]        extent_b;
  } item_t;

  typedef struct packed {
    logic       hit;
    logic [5:0] hit_index;
    logic       last;
  } result_t;

  typedef struct packed {
    logic               shape_kind;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic [19:0]        extent_a;
    logic [19:0]        extent_b;
  } shape_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              write_en;
    logic              load_probe;
    logic              issue;
    logic [IndexW-1:0] issue_idx;
    logic              flush;
  } cmd_t;

  // Strict overlap of two intervals [a, a+aw) and [b, b+bw) on one axis.
  function automatic logic axis_overlap(input logic signed [CoordW-1:0] a,
                                        input logic signed [CoordW-1:0] aw,
                                        input logic signed [CoordW-1:0] b,
                                        input logic signed [CoordW-1:0] bw);
    logic signed [CoordW-1:0] lo_min;
    logic signed [CoordW-1:0] hi_max;
    logic signed [CoordW-1:0] t0;
    logic signed [CoordW-1:0] t1;
    lo_min = (a < b) ? a : b;
    t0 = a - bw;
    t1 = b - aw;
    hi_max = (t0 > t1) ? t0 : t1;
    return lo_min > hi_max;
  endfunction

endpackage

// ===== src/sos_ctrl.sv =====
module sos_ctrl #(
  parameter int TABLE_ENTRIES = sos_pkg::DefTableEntries
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          action,
  output logic          busy,
  output sos_pkg::cmd_t cmd
);

  localparam int SlotDepth = (TABLE_ENTRIES < sos_pkg::MaxEntries) ?
                             TABLE_ENTRIES : sos_pkg::MaxEntries;
  localparam int IdxW      = $clog2(SlotDepth);
  localparam int DrainW    = $clog2(sos_pkg::PipeLat + 1);

  sos_pkg::state_t state, state_next;
  logic [IdxW-1:0]   cnt, cnt_next;
  logic [DrainW-1:0] drain, drain_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sos_pkg::ST_IDLE;
      cnt   <= '0;
      drain <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      drain <= drain_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    drain_next = drain;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      sos_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (action == sos_pkg::ActWrite) begin
            cmd.write_en = 1'b1;
          end else begin
            cmd.load_probe = 1'b1;
            cnt_next       = '0;
            state_next     = sos_pkg::ST_SCAN;
          end
        end
      end
      sos_pkg::ST_SCAN: begin
        cmd.issue     = 1'b1;
        cmd.issue_idx = sos_pkg::IndexW'(cnt);
        if (cnt == IdxW'(SlotDepth - 1)) begin
          drain_next = '0;
          state_next = sos_pkg::ST_DRAIN;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      sos_pkg::ST_DRAIN: begin
        if (drain == DrainW'(sos_pkg::PipeLat - 1)) begin
          state_next = sos_pkg::ST_DONE;
        end else begin
          drain_next = drain + 1'b1;
        end
      end
      sos_pkg::ST_DONE: begin
        cmd.flush  = 1'b1;
        state_next = sos_pkg::ST_IDLE;
      end
      default: state_next = sos_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== src/sos_datapath.sv =====
module sos_datapath #(
  parameter int TABLE_ENTRIES = sos_pkg::DefTableEntries
) (
  input  logic             clk,
  input  logic             rst,
  input  sos_pkg::item_t   item,
  input  sos_pkg::cmd_t    cmd,
  output sos_pkg::result_t result,
  output logic             result_strobe
);

  localparam int SlotDepth = (TABLE_ENTRIES < sos_pkg::MaxEntries) ?
                             TABLE_ENTRIES : sos_pkg::MaxEntries;
  localparam int IdxW = $clog2(SlotDepth);
  localparam int CW   = sos_pkg::CoordW;
  localparam int KW   = sos_pkg::RadW;
  localparam int IW   = sos_pkg::IndexW;

  // Shape table and its valid marks.
  sos_pkg::shape_t slot_mem [SlotDepth];
  logic [SlotDepth-1:0] slot_valid;

  sos_pkg::shape_t probe;
  logic            probe_skip;
  logic [IW-1:0]   probe_idx;

  logic [IdxW-1:0] widx;
  logic [IdxW-1:0] ridx;
  logic            wr_ok;

  assign widx  = item.entry_index[IdxW-1:0];
  assign ridx  = cmd.issue_idx[IdxW-1:0];
  assign wr_ok = cmd.write_en && (32'(item.entry_index) < TABLE_ENTRIES);

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      slot_mem[widx] <= '{shape_kind: item.shape_kind, pos_x: item.pos_x,
                          pos_y: item.pos_y, extent_a: item.extent_a,
                          extent_b: item.extent_b};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (wr_ok) begin
      slot_valid[widx] <= item.entry_live;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_probe) begin
      probe      <= '{shape_kind: item.shape_kind, pos_x: item.pos_x,
                      pos_y: item.pos_y, extent_a: item.extent_a,
                      extent_b: item.extent_b};
      probe_skip <= item.skip_own;
      probe_idx  <= item.entry_index;
    end
  end

  // Stage 0: registered table read.
  sos_pkg::shape_t ent;
  logic            s0_tag;
  logic [IW-1:0]   s0_idx;

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      ent <= slot_mem[ridx];
    end
    s0_idx <= cmd.issue_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_tag <= 1'b0;
    end else begin
      s0_tag <= cmd.issue && slot_valid[ridx] &&
                !(probe_skip && (probe_idx == cmd.issue_idx));
    end
  end

  // Stage 1: bounding boxes and the rectangle/circle roles.
  logic signed [CW-1:0] px, py, pa, pb, ex, ey, ea, eb;
  logic signed [CW-1:0] pbx, pby, pbw, pbh, ebx, eby, ebw, ebh;
  logic signed [CW-1:0] rx_c, ry_c, rw_c, rh_c, cx_c, cy_c;
  logic [KW-1:0]        k_c;
  logic                 rr_c, cc_c;

  always_comb begin
    px = CW'(probe.pos_x);
    py = CW'(probe.pos_y);
    pa = CW'(probe.extent_a);
    pb = CW'(probe.extent_b);
    ex = CW'(ent.pos_x);
    ey = CW'(ent.pos_y);
    ea = CW'(ent.extent_a);
    eb = CW'(ent.extent_b);
    rr_c = (probe.shape_kind == sos_pkg::KindRect) && (ent.shape_kind == sos_pkg::KindRect);
    cc_c = (probe.shape_kind != sos_pkg::KindRect) && (ent.shape_kind != sos_pkg::KindRect);
    if (probe.shape_kind == sos_pkg::KindRect) begin
      pbx = px;      pby = py;      pbw = pa;      pbh = pb;
    end else begin
      pbx = px - pa; pby = py - pa; pbw = pa + pa; pbh = pa + pa;
    end
    if (ent.shape_kind == sos_pkg::KindRect) begin
      ebx = ex;      eby = ey;      ebw = ea;      ebh = eb;
    end else begin
      ebx = ex - ea; eby = ey - ea; ebw = ea + ea; ebh = ea + ea;
    end
    if (cc_c) begin
      // Centre distance appears as a zero-size "rectangle" at the probe.
      rx_c = px; ry_c = py; rw_c = '0; rh_c = '0;
      cx_c = ex; cy_c = ey;
      k_c  = KW'(probe.extent_a) + KW'(ent.extent_a);
    end else if (probe.shape_kind == sos_pkg::KindRect) begin
      rx_c = px; ry_c = py; rw_c = pa; rh_c = pb;
      cx_c = ex; cy_c = ey;
      k_c  = KW'(ent.extent_a);
    end else begin
      rx_c = ex; ry_c = ey; rw_c = ea; rh_c = eb;
      cx_c = px; cy_c = py;
      k_c  = KW'(probe.extent_a);
    end
  end

  logic signed [CW-1:0] s1_pbx, s1_pby, s1_pbw, s1_pbh, s1_ebx, s1_eby, s1_ebw, s1_ebh;
  logic signed [CW-1:0] s1_rx, s1_ry, s1_rw, s1_rh, s1_cx, s1_cy;
  logic [KW-1:0]        s1_k;
  logic                 s1_rr, s1_cc, s1_tag;
  logic [IW-1:0]        s1_idx;

  always_ff @(posedge clk) begin
    s1_pbx <= pbx; s1_pby <= pby; s1_pbw <= pbw; s1_pbh <= pbh;
    s1_ebx <= ebx; s1_eby <= eby; s1_ebw <= ebw; s1_ebh <= ebh;
    s1_rx  <= rx_c; s1_ry <= ry_c; s1_rw <= rw_c; s1_rh <= rh_c;
    s1_cx  <= cx_c; s1_cy <= cy_c; s1_k <= k_c;
    s1_rr  <= rr_c; s1_cc <= cc_c; s1_idx <= s0_idx;
  end

  // Stage 2: box test, corner offsets and edge spans.
  logic                 s2_box, s2_span, s2_rr, s2_cc, s2_tag;
  logic signed [CW-1:0] s2_dxa, s2_dxb, s2_dya, s2_dyb;
  logic [KW-1:0]        s2_k;
  logic [IW-1:0]        s2_idx;

  always_ff @(posedge clk) begin
    s2_box  <= sos_pkg::axis_overlap(s1_pbx, s1_pbw, s1_ebx, s1_ebw) &&
               sos_pkg::axis_overlap(s1_pby, s1_pbh, s1_eby, s1_ebh);
    s2_dxa  <= s1_rx - s1_cx;
    s2_dxb  <= s1_rx + s1_rw - s1_cx;
    s2_dya  <= s1_ry - s1_cy;
    s2_dyb  <= s1_ry + s1_rh - s1_cy;
    s2_span <= ((s1_rx < s1_cx) && (s1_cx < s1_rx + s1_rw)) ||
               ((s1_ry < s1_cy) && (s1_cy < s1_ry + s1_rh));
    s2_k    <= s1_k;
    s2_rr   <= s1_rr;
    s2_cc   <= s1_cc;
    s2_idx  <= s1_idx;
  end

  // Stage 3: squares.
  logic [2*CW-1:0] s3_sxa, s3_sxb, s3_sya, s3_syb;
  logic [2*KW-1:0] s3_k2;
  logic            s3_box, s3_span, s3_rr, s3_cc, s3_tag;
  logic [IW-1:0]   s3_idx;

  always_ff @(posedge clk) begin
    s3_sxa  <= s2_dxa * s2_dxa;
    s3_sxb  <= s2_dxb * s2_dxb;
    s3_sya  <= s2_dya * s2_dya;
    s3_syb  <= s2_dyb * s2_dyb;
    s3_k2   <= s2_k * s2_k;
    s3_box  <= s2_box;
    s3_span <= s2_span;
    s3_rr   <= s2_rr;
    s3_cc   <= s2_cc;
    s3_idx  <= s2_idx;
  end

  // Stage 4: nearest corner against the radius, final hit flag.
  logic [2*CW-1:0] minx, miny;
  logic [2*CW:0]   dist2;
  logic            corner_in, hit_c;
  logic            s4_hit;
  logic [IW-1:0]   s4_idx;

  always_comb begin
    minx      = (s3_sxa < s3_sxb) ? s3_sxa : s3_sxb;
    miny      = (s3_sya < s3_syb) ? s3_sya : s3_syb;
    dist2     = (2*CW+1)'(minx) + (2*CW+1)'(miny);
    corner_in = dist2 < (2*CW+1)'(s3_k2);
    hit_c     = s3_tag && s3_box && (s3_rr || corner_in || (!s3_cc && s3_span));
  end

  always_ff @(posedge clk) begin
    s4_idx <= s3_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_tag <= 1'b0;
      s2_tag <= 1'b0;
      s3_tag <= 1'b0;
      s4_hit <= 1'b0;
    end else begin
      s1_tag <= s0_tag;
      s2_tag <= s1_tag;
      s3_tag <= s2_tag;
      s4_hit <= hit_c;
    end
  end

  // One hit is held back so that the final one can carry the last mark.
  logic          pend_valid;
  logic [IW-1:0] pend_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid    <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      priority if (cmd.load_probe) begin
        pend_valid    <= 1'b0;
        result_strobe <= 1'b0;
      end else if (s4_hit) begin
        pend_valid    <= 1'b1;
        result_strobe <= pend_valid;
      end else if (cmd.flush) begin
        pend_valid    <= 1'b0;
        result_strobe <= 1'b1;
      end else begin
        result_strobe <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s4_hit) begin
      pend_idx <= s4_idx;
      result   <= '{hit: 1'b1, hit_index: pend_idx, last: 1'b0};
    end else if (cmd.flush) begin
      result <= pend_valid ? '{hit: 1'b1, hit_index: pend_idx, last: 1'b1}
                           : '{hit: 1'b0, hit_index: '0, last: 1'b1};
    end
  end

endmodule

// ===== src/shape_overlap_scan.sv =====
// Shape table with overlap scan. A word with start high while busy is low is
// taken. A write word (action 0) stores one rectangle or circle with its valid
// mark and produces nothing. A query word (action 1) keeps busy high while the
// table (at most 64 entries) is scanned and the pipeline drains: one entry is
// read from the table memory per cycle and runs through a five-stage compare
// pipeline. Results leave as one-cycle pulses of result_strobe, one word per
// overlapping entry in index order, the final one with last set, or a single
// no-hit word with last set. The receiver cannot stall these words and must
// take each in its cycle. The final word of a query appears in the first
// cycle in which busy is low again.
module shape_overlap_scan #(
  parameter int TABLE_ENTRIES = sos_pkg::DefTableEntries
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  sos_pkg::item_t   item,
  output sos_pkg::result_t result,
  output logic             result_strobe
);

  `include "assert_macros.svh"

  sos_pkg::cmd_t cmd;

  // The controller sequences writes and the entry scan.
  sos_ctrl #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .action(item.action),
    .busy  (busy),
    .cmd   (cmd)
  );

  // The datapath holds the table, the compare pipeline and the result word.
  sos_datapath #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .result       (result),
    .result_strobe(result_strobe)
  );

  // A query keeps the block busy in the following cycle.
  `ASSERT_NEXT(a_query_busy, start && !busy && item.action, busy)
  // A no-hit word is always the final word and names entry zero.
  `ASSERT_SAME(a_nohit_last, result_strobe && !result.hit, result.last && result.hit_index == '0)
  // Nothing follows the final word of a query in the next cycle.
  `ASSERT_NEXT(a_last_alone, result_strobe && result.last, !result_strobe)

endmodule

// ===== tb/shape_overlap_scan_test.sv =====
module shape_overlap_scan_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sos_pkg::*;

  localparam int Slots = 64;
  // Longest query: busy over the whole table scan and drain, plus the result tail.
  localparam int DrainCycles = 80;

  logic    clk;
  logic    rst;
  logic    start;
  logic    busy;
  item_t   item;
  result_t result;
  logic    result_strobe;

  shape_overlap_scan u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .result(result),
    .result_strobe(result_strobe)
  );

  // One row of the directed table. Rows with a typed result expect exactly
  // that one word; all others are checked against the predictor.
  typedef struct {
    item_t   w;
    bit      typed;
    result_t want;
  } dir_row_t;

  // Shadow copy of the shape table, kept up to date on every accepted write.
  bit     shadow_valid [Slots];
  shape_t shadow_shape [Slots];

  result_t pending_words[$];
  int      err_count;
  int      words_seen;
  int      hits_seen;
  int      queries_sent;
  int      writes_sent;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs or never answers a query.
  initial begin
    #1ms;
    $display("shape_overlap_scan verification failed");
    $finish;
  end

  task automatic report_mismatch(input string what);
    err_count++;
    $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  // Strict interval test on both axes, exactly as the corner/size form states:
  // min of the corners must lie above the larger of the two far-edge shifts.
  function automatic bit boxes_meet(longint ax, longint ay, longint aw, longint ah,
                                    longint bx, longint by, longint bw, longint bh);
    longint lo;
    longint hi;
    bit     ok_x;
    lo = (ax < bx) ? ax : bx;
    hi = ((ax - bw) > (bx - aw)) ? (ax - bw) : (bx - aw);
    ok_x = lo > hi;
    lo = (ay < by) ? ay : by;
    hi = ((ay - bh) > (by - ah)) ? (ay - bh) : (by - ah);
    return ok_x && (lo > hi);
  endfunction

  function automatic bit point_inside(longint px, longint py, longint cx, longint cy,
                                      longint r);
    longint dx;
    longint dy;
    dx = px - cx;
    dy = py - cy;
    return dx * dx + dy * dy < r * r;
  endfunction

  // Rectangle against circle: the rectangle must meet the circle's bounding
  // box, and then a corner inside the circle or the centre within an edge
  // span is enough.
  function automatic bit rect_meets_circle(longint ax, longint ay, longint aw, longint ah,
                                           longint cx, longint cy, longint r);
    if (!boxes_meet(ax, ay, aw, ah, cx - r, cy - r, 2 * r, 2 * r)) return 1'b0;
    return point_inside(ax, ay, cx, cy, r) ||
           point_inside(ax + aw, ay, cx, cy, r) ||
           point_inside(ax + aw, ay + ah, cx, cy, r) ||
           point_inside(ax, ay + ah, cx, cy, r) ||
           (ax < cx && cx < ax + aw) || (ay < cy && cy < ay + ah);
  endfunction

  function automatic bit shapes_meet(shape_t p, shape_t e);
    longint px;
    longint py;
    longint pa;
    longint pb;
    longint ex;
    longint ey;
    longint ea;
    longint eb;
    longint dx;
    longint dy;
    longint rs;
    px = p.pos_x;
    py = p.pos_y;
    pa = p.extent_a;
    pb = p.extent_b;
    ex = e.pos_x;
    ey = e.pos_y;
    ea = e.extent_a;
    eb = e.extent_b;
    if (p.shape_kind == KindRect) begin
      if (e.shape_kind == KindRect) return boxes_meet(px, py, pa, pb, ex, ey, ea, eb);
      return rect_meets_circle(px, py, pa, pb, ex, ey, ea);
    end
    if (e.shape_kind == KindRect) return rect_meets_circle(ex, ey, ea, eb, px, py, pa);
    dx = ex - px;
    dy = ey - py;
    rs = pa + ea;
    return boxes_meet(px - pa, py - pa, 2 * pa, 2 * pa, ex - ea, ey - ea, 2 * ea, 2 * ea) &&
           rs * rs > dx * dx + dy * dy;
  endfunction

  // Applies one accepted word to the shadow table and queues the words that
  // a query must produce, in index order with the final one marked.
  task automatic predict_scan(input item_t w);
    shape_t  probe;
    result_t r;
    int      first;
    probe = '{w.shape_kind, w.pos_x, w.pos_y, w.extent_a, w.extent_b};
    if (w.action == ActWrite) begin
      writes_sent++;
      shadow_valid[w.entry_index] = w.entry_live;
      shadow_shape[w.entry_index] = probe;
      return;
    end
    queries_sent++;
    first = pending_words.size();
    for (int i = 0; i < Slots; i++) begin
      if (!shadow_valid[i]) continue;
      if (w.skip_own && i == int'(w.entry_index)) continue;
      if (shapes_meet(probe, shadow_shape[i])) begin
        r = '{1'b1, 6'(i), 1'b0};
        pending_words.insert(pending_words.size(), r);
      end
    end
    if (pending_words.size() == first) begin
      r = '{1'b0, 6'd0, 1'b1};
      pending_words.insert(pending_words.size(), r);
    end else begin
      pending_words[pending_words.size() - 1].last = 1'b1;
    end
  endtask

  // Drives one word and holds it until the block takes it. When the sender
  // is to idle afterwards, start drops for a random stretch.
  task automatic send_word(input item_t w, input bit typed, input result_t want,
                           input int idle_pct);
    item <= w;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    if (typed) begin
      // Writes still go through the shadow table; a typed query is ours alone.
      queries_sent++;
      pending_words.insert(pending_words.size(), want);
    end else begin
      predict_scan(w);
    end
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic item_t mk(bit act, int idx, bit skip, bit live, bit kind,
                               int x, int y, int a, int b);
    item_t w;
    w.action = act;
    w.entry_index = 6'(idx);
    w.skip_own = skip;
    w.entry_live = live;
    w.shape_kind = kind;
    w.pos_x = 24'(x);
    w.pos_y = 24'(y);
    w.extent_a = 20'(a);
    w.extent_b = 20'(b);
    return w;
  endfunction

  // Coordinates mostly fall in a small patch so shapes actually collide;
  // now and then a full-range value exercises the top bits.
  function automatic int rand_coord();
    if ($urandom_range(9) == 0) return int'($urandom);
    return int'($urandom_range(0, 6143)) - 3072;
  endfunction

  function automatic int rand_extent();
    if ($urandom_range(9) == 0) return int'($urandom);
    return int'($urandom_range(0, 2047));
  endfunction

  // Every result word is compared with the oldest one waiting.
  always @(posedge clk) begin
    if (!rst && result_strobe) begin
      words_seen++;
      if (result.hit) hits_seen++;
      if (pending_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word hit=%0b index=%0d last=%0b",
                                  result.hit, result.hit_index, result.last));
      end else begin
        if (result.hit !== pending_words[0].hit)
          report_mismatch($sformatf("hit %0b, expected %0b", result.hit,
                                    pending_words[0].hit));
        if (result.hit_index !== pending_words[0].hit_index)
          report_mismatch($sformatf("hit_index %0d, expected %0d", result.hit_index,
                                    pending_words[0].hit_index));
        if (result.last !== pending_words[0].last)
          report_mismatch($sformatf("last %0b, expected %0b", result.last,
                                    pending_words[0].last));
        void'(pending_words.pop_front());
      end
    end
  end

  initial begin
    dir_row_t rows[$];
    result_t  no_hit;
    result_t  none;
    int       idle_pct;
    int       wait_cycles;
    item_t    w;

    no_hit = '{1'b0, 6'd0, 1'b1};
    none = '0;
    err_count = 0;
    words_seen = 0;
    hits_seen = 0;
    queries_sent = 0;
    writes_sent = 0;
    for (int i = 0; i < Slots; i++) shadow_valid[i] = 1'b0;

    rst = 1'b1;
    start = 1'b0;
    item = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed table: an empty table first, then small shapes around the
    // origin, touching cases, skips, a dead entry and the field extremes.
    rows.insert(rows.size(), '{mk(1, 0, 0, 0, 0, 0, 0, 256, 256), 1, no_hit});
    rows.insert(rows.size(), '{mk(0, 0, 0, 1, 0, 0, 0, 256, 256), 0, none});
    rows.insert(rows.size(), '{mk(0, 1, 0, 1, 1, 512, 0, 256, 0), 0, none});
    rows.insert(rows.size(), '{mk(0, 2, 0, 0, 0, 0, 0, 1000, 1000), 0, none});
    rows.insert(rows.size(), '{mk(0, 63, 0, 1, 0, -8388608, -8388608, 1048575, 1048575), 0, none});
    rows.insert(rows.size(), '{mk(0, 62, 0, 1, 1, 8388607, 8388607, 1048575, 0), 0, none});
    rows.insert(rows.size(), '{mk(1, 0, 0, 0, 0, 128, 128, 64, 64), 0, none});
    // Rectangle that only touches entry 0 on its right edge.
    rows.insert(rows.size(), '{mk(1, 0, 0, 0, 0, 256, 0, 100, 100), 0, none});
    rows.insert(rows.size(), '{mk(1, 0, 1, 0, 0, 128, 128, 64, 64), 0, none});
    rows.insert(rows.size(), '{mk(1, 0, 0, 1, 1, 256, 0, 200, 0), 0, none});
    rows.insert(rows.size(), '{mk(1, 1, 1, 0, 1, 600, 50, 100, 0), 0, none});
    // Circles touching exactly: radii sum equals the distance.
    rows.insert(rows.size(), '{mk(1, 5, 0, 0, 1, 1024, 0, 256, 0), 0, none});
    // Rectangle corner just inside the circle of entry 1.
    rows.insert(rows.size(), '{mk(1, 5, 0, 0, 0, 650, 150, 300, 300), 0, none});
    // Centre of entry 1 inside the x span of a thin rectangle.
    rows.insert(rows.size(), '{mk(1, 5, 0, 0, 0, 400, 200, 300, 20), 0, none});
    // Zero-size probes never overlap.
    rows.insert(rows.size(), '{mk(1, 3, 0, 0, 0, 100, 100, 0, 0), 1, no_hit});
    rows.insert(rows.size(), '{mk(1, 3, 0, 0, 1, 100, 100, 0, 0), 1, no_hit});
    rows.insert(rows.size(), '{mk(1, 63, 0, 0, 0, -8388608, -8388608, 1048575, 1048575), 0, none});
    rows.insert(rows.size(), '{mk(1, 62, 1, 0, 1, 8388607, 8388607, 1048575, 1048575), 0, none});
    rows.insert(rows.size(), '{mk(1, 63, 1, 1, 1, 0, 0, 1048575, 1048575), 0, none});
    rows.insert(rows.size(), '{mk(0, 0, 0, 0, 0, 0, 0, 256, 256), 0, none});
    rows.insert(rows.size(), '{mk(1, 0, 0, 0, 0, 128, 128, 64, 64), 0, none});

    foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].want, 17);

    // Random part in three idling phases. Writes refill entries with small
    // shapes near the origin; most words are queries against them.
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 17 : (phase == 1) ? 66 : 0;
      for (int n = 0; n < 33; n++) begin
        w.action = ($urandom_range(99) < 55);
        w.entry_index = 6'($urandom_range(0, 63));
        w.skip_own = 1'($urandom);
        w.entry_live = ($urandom_range(9) != 0);
        w.shape_kind = 1'($urandom);
        w.pos_x = 24'(rand_coord());
        w.pos_y = 24'(rand_coord());
        w.extent_a = 20'(rand_extent());
        w.extent_b = 20'(rand_extent());
        send_word(w, 1'b0, none, idle_pct);
      end
    end

    start <= 1'b0;
    wait_cycles = 0;
    while (pending_words.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (DrainCycles) @(posedge clk);
    if (pending_words.size() != 0)
      report_mismatch($sformatf("%0d expected words never arrived", pending_words.size()));

    $display("Covered %0d writes and %0d queries; %0d result words, %0d of them hits.",
             writes_sent, queries_sent, words_seen, hits_seen);
    $display("Mismatches counted: %0d", err_count);
    if (err_count == 0) begin
      $display("shape_overlap_scan verification clean");
    end else begin
      $display("shape_overlap_scan verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/sos_pkg.sv
src/sos_ctrl.sv
src/sos_datapath.sv
src/shape_overlap_scan.sv
tb/shape_overlap_scan_test.sv
